// ----- rtl/core/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Holds the input and result word layouts, character codes, the cursor
// command and the sequencer states.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // item kinds
  localparam logic KIND_PUT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // character codes
  localparam logic [7:0] CODE_NEWLINE = 8'd10;
  localparam logic [7:0] CODE_RETURN  = 8'd13;
  localparam logic [7:0] CODE_SPACE   = 8'd32;

  // attribute after reset: white on black
  localparam logic [7:0] ATTR_RESET = 8'h0F;

  // input word
  typedef struct packed {
    logic        kind;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } in_item_t;

  // result word
  typedef struct packed {
    logic [15:0] read_data;
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic        scrolled;
  } out_item_t;

  // cursor update request from the sequencer
  typedef struct packed {
    logic       step;
    logic [7:0] code;
  } cur_cmd_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_BLANK,
    ST_DONE
  } tcw_state_t;

endpackage

// ----- rtl/core/tcw_cursor.sv -----
// ----------------------------------------------------------------------------
// tcw_cursor: cursor position tracker
// Keeps column, row and the linear cell address of the cursor, and applies
// one character at a time: carriage return, newline, or a printed character
// with wrap. Flags when the row runs past the last row.
// ----------------------------------------------------------------------------
module tcw_cursor #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  tcw_pkg::cur_cmd_t                     cmd,
  output logic [$clog2(COLUMNS)-1:0]            col,
  output logic [$clog2(ROWS)-1:0]               row,
  output logic [$clog2(COLUMNS*ROWS)-1:0]       addr,
  output logic                                  scroll
);
  import tcw_pkg::*;

  localparam int COL_W     = $clog2(COLUMNS);
  localparam int ROW_W     = $clog2(ROWS);
  localparam int ADDR_W    = $clog2(COLUMNS * ROWS);
  localparam int LAST_BASE = (ROWS - 1) * COLUMNS;

  logic [COL_W-1:0]  col_r,  col_nxt;
  logic [ROW_W-1:0]  row_r,  row_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [ADDR_W-1:0] line_base;
  logic              row_adv;
  logic              scroll_nxt;

  // work out the next cursor position
  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    addr_nxt   = addr_r;
    row_adv    = 1'b0;
    scroll_nxt = 1'b0;
    line_base  = addr_r - ADDR_W'(col_r);
    if (cmd.step) begin
      if (cmd.code == CODE_RETURN) begin
        col_nxt  = '0;
        addr_nxt = line_base;
      end else if (cmd.code == CODE_NEWLINE) begin
        col_nxt  = '0;
        row_adv  = 1'b1;
        addr_nxt = line_base + ADDR_W'(COLUMNS);
      end else begin
        addr_nxt = addr_r + ADDR_W'(1);
        if (col_r == COL_W'(COLUMNS - 1)) begin
          col_nxt = '0;
          row_adv = 1'b1;
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end
      // past the last row: stay there, the screen scrolls
      if (row_adv) begin
        if (row_r == ROW_W'(ROWS - 1)) begin
          scroll_nxt = 1'b1;
          addr_nxt   = ADDR_W'(LAST_BASE);
        end else begin
          row_nxt = row_r + ROW_W'(1);
        end
      end
    end
  end

  // hold the cursor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      addr_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      addr_r <= addr_nxt;
    end
  end

  assign col    = col_r;
  assign row    = row_r;
  assign addr   = addr_r;
  assign scroll = scroll_nxt;

endmodule

// ----- rtl/core/text_console_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console engine
// Character cell store with a cursor, newline, carriage return, wrap and
// scroll, plus a cell read-back.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: an item is taken on a rising edge with start high and busy
//   low. A put (kind 0) writes char_code with the current attribute at the
//   cursor; a read (kind 1) returns the cell at cell_index, zero beyond the
//   screen. Every item gives exactly one result word on out_item, marked by
//   out_strobe for one cycle; the receiver cannot stall it.
//   Configuration: cfg_wr_en with cfg_wr_data writes the attribute byte,
//   taken at once; write it only while busy is low and no result is pending.
//   Sequencing: a read or a put that does not scroll passes through the EXEC
//   and DONE states, and busy drops with its result, so a new item is taken
//   only after the last one has given its result. A put that scrolls copies
//   each cell one row up through the write port and the registered read port,
//   one cell a cycle, then blanks the last row with spaces in the current
//   attribute.
//   Reset: the cursor goes home, the attribute returns to 0x0F and a clearing
//   pass zeroes every cell with busy high; configuration writes are taken
//   during it.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  tcw_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output tcw_pkg::out_item_t out_item,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data
);
  import tcw_pkg::*;

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int LAST_BASE  = (ROWS - 1) * COLUMNS;
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  tcw_state_t        state_r, state_nxt;
  logic [ADDR_W-1:0] sweep_r, sweep_nxt;
  logic              copy_vld_r, copy_vld_nxt;
  logic [ADDR_W-1:0] copy_dst_r, copy_dst_nxt;
  logic              scroll_r, scroll_nxt;
  logic [7:0]        attr_r;
  in_item_t          item_r;
  logic              out_strobe_r, out_strobe_nxt;
  out_item_t         out_item_r, out_item_nxt;

  // cell memory
  logic [15:0]       cell_mem [CELL_COUNT];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [15:0]       mem_q_r;

  // cursor
  cur_cmd_t          cur_cmd;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [ADDR_W-1:0] cur_addr;
  logic              cur_scroll;
  logic              rd_in_range;

  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cur_cmd),
    .col    (cur_col),
    .row    (cur_row),
    .addr   (cur_addr),
    .scroll (cur_scroll)
  );

  assign rd_in_range = (32'(item_r.cell_index) < 32'(CELL_COUNT));

  // sequencer: next state, memory port and result word
  always_comb begin
    state_nxt      = state_r;
    sweep_nxt      = sweep_r;
    copy_vld_nxt   = 1'b0;
    copy_dst_nxt   = copy_dst_r;
    scroll_nxt     = scroll_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    mem_we         = 1'b0;
    mem_waddr      = sweep_r;
    mem_wdata      = '0;
    mem_raddr      = ADDR_W'(item_r.cell_index);
    cur_cmd.step   = 1'b0;
    cur_cmd.code   = item_r.char_code;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_r;
        mem_wdata = '0;
        if (sweep_r == ADDR_W'(CELL_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          sweep_nxt = sweep_r + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        scroll_nxt = 1'b0;
        if (item_r.kind == KIND_PUT) begin
          // store every character but return and newline, and move the cursor
          if (item_r.char_code != CODE_RETURN && item_r.char_code != CODE_NEWLINE) begin
            mem_we    = 1'b1;
            mem_waddr = cur_addr;
            mem_wdata = {attr_r, item_r.char_code};
          end
          cur_cmd.step = 1'b1;
          scroll_nxt   = cur_scroll;
          if (cur_scroll) begin
            state_nxt = ST_SCROLL;
            sweep_nxt = '0;
          end else begin
            state_nxt = ST_DONE;
          end
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_SCROLL: begin
        // write back the cell read in the previous cycle, one row higher
        if (copy_vld_r) begin
          mem_we    = 1'b1;
          mem_waddr = copy_dst_r;
          mem_wdata = mem_q_r;
        end
        if (sweep_r == ADDR_W'(LAST_BASE)) begin
          state_nxt = ST_BLANK;
        end else begin
          mem_raddr    = sweep_r + ADDR_W'(COLUMNS);
          copy_vld_nxt = 1'b1;
          copy_dst_nxt = sweep_r;
          sweep_nxt    = sweep_r + ADDR_W'(1);
        end
      end
      ST_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_r;
        mem_wdata = {attr_r, CODE_SPACE};
        if (sweep_r == ADDR_W'(CELL_COUNT - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          sweep_nxt = sweep_r + ADDR_W'(1);
        end
      end
      ST_DONE: begin
        out_strobe_nxt             = 1'b1;
        out_item_nxt.read_data     = '0;
        if (item_r.kind == KIND_READ && rd_in_range) begin
          out_item_nxt.read_data = mem_q_r;
        end
        out_item_nxt.cursor_column = 7'(cur_col);
        out_item_nxt.cursor_row    = 5'(cur_row);
        out_item_nxt.scrolled      = (item_r.kind == KIND_PUT) && scroll_r;
        state_nxt                  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      sweep_r      <= '0;
      copy_vld_r   <= 1'b0;
      scroll_r     <= 1'b0;
      attr_r       <= ATTR_RESET;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sweep_r      <= sweep_nxt;
      copy_vld_r   <= copy_vld_nxt;
      scroll_r     <= scroll_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_wr_en) begin
        attr_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    copy_dst_r <= copy_dst_nxt;
    out_item_r <= out_item_nxt;
    if (state_r == ST_IDLE && start) begin
      item_r <= in_item;
    end
  end

  // cell memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem[mem_waddr] <= mem_wdata;
    end
    mem_q_r <= cell_mem[mem_raddr];
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

// ----- rtl/core/tcw_checker.sv -----
// ----------------------------------------------------------------------------
// tcw_checker: port-level checks of the text console writer
// Watches the command handshake and the result strobe and checks the
// cursor reported with a scroll.
// ----------------------------------------------------------------------------
module tcw_checker #(
  parameter int ROWS    = 25
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_strobe,
  input tcw_pkg::out_item_t out_item
);
  import tcw_pkg::*;

  // a taken item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after taking an item");

  // results never come in adjacent cycles
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for two cycles");

  // a result is shown only once the block is ready again
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while busy");

  // a scroll leaves the cursor at the start of the last row
  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.scrolled) |->
      (out_item.cursor_row == 5'(ROWS - 1)) && (out_item.cursor_column == 7'd0))
    else $error("cursor not at start of last row after scroll");

endmodule

bind text_console_writer tcw_checker #(
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);
